>>> design/tbt_pkg.sv
// Shared constants, types and codes of the terminal byte tokenizer.
`timescale 1ns / 1ps

package tbt_pkg;

	// Largest token the buffer holds, in bytes (range 4 to 64).
	localparam int TOKEN_MAX = 16;
	localparam int CNT_W     = $clog2(TOKEN_MAX + 1);
	localparam int IDX_W     = $clog2(TOKEN_MAX);

	// Limit register.
	localparam int CFG_W       = 5;
	localparam int LIMIT_MIN   = 4;
	localparam int LIMIT_RESET = 16;

	// Depth of the command queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 2;

	// Token kinds.
	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_CTRL = 2'd1;
	localparam logic [1:0] KIND_ESC  = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	// Input word modes.
	localparam logic MODE_DATA  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// A classified input word.
	typedef struct packed {
		logic       mode;
		logic [7:0] data;
		logic       is_ctrl;
		logic       is_esc;
		logic [2:0] lead_len;
		logic       is_cont;
		logic       is_o;
		logic       is_lbr;
		logic       is_param;
		logic       is_qmark;
		logic       is_final;
	} cmd_t;

	// Head of the command queue as the back end sees it.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

>>> design/tbt_if.sv
// Handshake channels of the terminal byte tokenizer: input bytes and output tokens.
`timescale 1ns / 1ps

interface tbt_byte_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface tbt_token_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_byte;
	logic [1:0] token_kind;
	logic       token_end;
	logic       overflow;

	modport source (output valid, output token_byte, output token_kind, output token_end,
		output overflow, input ready);
	modport sink (input valid, input token_byte, input token_kind, input token_end,
		input overflow, output ready);
endinterface

>>> design/tbt_front.sv
// Front end: accepts input words, classifies each byte and queues the result.
`timescale 1ns / 1ps

module tbt_front (
	input  logic            clk,
	input  logic            arst_n,
	tbt_byte_if.sink        bytes,
	output tbt_pkg::q_head_t head,
	input  logic            pop
);
	import tbt_pkg::*;

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_DEL   = 8'h7F;
	localparam logic [7:0] ASCII_ESC   = 8'h1B;

	function automatic cmd_t classify(input logic m, input logic [7:0] b);
		cmd_t c;
		c.mode     = m;
		c.data     = b;
		c.is_ctrl  = (b < ASCII_SPACE) || (b == ASCII_DEL);
		c.is_esc   = (b == ASCII_ESC);
		if (b < 8'h80) c.lead_len = 3'd1;
		else if (b < 8'hC0) c.lead_len = 3'd0;
		else if (b < 8'hE0) c.lead_len = 3'd2;
		else if (b < 8'hF0) c.lead_len = 3'd3;
		else if (b < 8'hF8) c.lead_len = 3'd4;
		else c.lead_len = 3'd0;
		c.is_cont  = (b[7:6] == 2'b10);
		c.is_o     = (b == "O");
		c.is_lbr   = (b == "[");
		c.is_param = ((b >= "0") && (b <= "9")) || (b == ";");
		c.is_qmark = (b == "?");
		c.is_final = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z")) ||
			(b == "~") || (b == "$") || (b == "^") || (b == "@");
		return c;
	endfunction

	cmd_t              q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;

	assign bytes.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push        = bytes.valid && bytes.ready;

	assign head.valid = (count_q != '0);
	assign head.cmd   = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= classify(bytes.mode, bytes.data_byte);
	end

endmodule

>>> design/tbt_back.sv
// Back end: holds the token buffer and parse state and sends tokens one byte a cycle unless the token sink stalls.
`timescale 1ns / 1ps

module tbt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tbt_pkg::q_head_t           head,
	output logic                       pop,
	input  logic                       cfg_we,
	input  logic [tbt_pkg::CFG_W-1:0]  cfg_data,
	tbt_token_if.source                tokens
);
	import tbt_pkg::*;

	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FRESH = 2'd1;
	localparam logic [1:0] S_RUN   = 2'd2;
	localparam logic [1:0] S_MOVE  = 2'd3;

	// Parse phases.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_ESC       = 3'd1;
	localparam logic [2:0] PH_ESC_O     = 3'd2;
	localparam logic [2:0] PH_CSI_FIRST = 3'd3;
	localparam logic [2:0] PH_CSI_BODY  = 3'd4;

	// What follows a run.
	localparam logic [1:0] TAIL_DONE  = 2'd0;
	localparam logic [1:0] TAIL_FRESH = 2'd1;
	localparam logic [1:0] TAIL_MOVE  = 2'd2;

	logic [7:0]       pend_q [TOKEN_MAX];
	logic [CNT_W-1:0] cnt_q, cs_q;
	logic [1:0]       need_q;
	logic [2:0]       phase_q;
	logic [1:0]       st_q;
	logic [CFG_W-1:0] limit_q;
	logic             bad_pend_q;

	logic [CNT_W-1:0] rd_q, end_q, bad_lo_q, bad_hi_q, mv_src_q, mv_n_q, mv_j_q;
	logic [1:0]       kind_q, tail_q;
	logic             ovf_q, each_q;
	cmd_t             cur_q;

	logic             ov_q, oend_q, oovf_q;
	logic [7:0]       obyte_q;
	logic [1:0]       okind_q;

	logic [CNT_W-1:0] n_cnt, n_cs, n_rd, n_end, n_bad_lo, n_bad_hi, n_mv_src, n_mv_n, n_mv_j;
	logic [1:0]       n_need, n_st, n_kind, n_tail;
	logic [2:0]       n_phase;
	logic             n_bad_pend, n_ovf, n_each;
	cmd_t             n_cur;

	logic             emit_req, e_end, e_ovf;
	logic [7:0]       e_byte;
	logic [1:0]       e_kind;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx, rd_idx;
	logic [7:0]       wr_data, rd_data;

	logic             slot_free, fresh_go, csi_param;
	cmd_t             c;
	logic [CNT_W-1:0] lim, cnt_inc, cs_inc;
	logic [CNT_W:0]   cs_plus_lead;
	logic [CMP_W-1:0] cfg_ext;

	// Limit in use: the register held to LIMIT_MIN..TOKEN_MAX.
	assign cfg_ext = CMP_W'(limit_q);
	always_comb begin
		if (cfg_ext < CMP_W'(LIMIT_MIN)) lim = CNT_W'(LIMIT_MIN);
		else if (cfg_ext > CMP_W'(TOKEN_MAX)) lim = CNT_W'(TOKEN_MAX);
		else lim = CNT_W'(cfg_ext);
	end

	assign slot_free    = !ov_q || tokens.ready;
	assign c            = (st_q == S_FRESH) ? cur_q : head.cmd;
	assign cnt_inc      = cnt_q + CNT_W'(1);
	assign cs_inc       = cs_q + CNT_W'(1);
	assign cs_plus_lead = {1'b0, cs_q} + (CNT_W + 1)'(c.lead_len);
	assign csi_param    = c.is_param || ((phase_q == PH_CSI_FIRST) && c.is_qmark);
	assign rd_data      = pend_q[rd_idx];

	always_comb begin
		n_cnt      = cnt_q;
		n_cs       = cs_q;
		n_need     = need_q;
		n_phase    = phase_q;
		n_st       = st_q;
		n_bad_pend = bad_pend_q;
		n_rd       = rd_q;
		n_end      = end_q;
		n_kind     = kind_q;
		n_ovf      = ovf_q;
		n_each     = each_q;
		n_tail     = tail_q;
		n_bad_lo   = bad_lo_q;
		n_bad_hi   = bad_hi_q;
		n_cur      = cur_q;
		n_mv_src   = mv_src_q;
		n_mv_n     = mv_n_q;
		n_mv_j     = mv_j_q;
		emit_req   = 1'b0;
		e_byte     = c.data;
		e_kind     = KIND_TEXT;
		e_end      = 1'b1;
		e_ovf      = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = cnt_q[IDX_W-1:0];
		wr_data    = c.data;
		rd_idx     = rd_q[IDX_W-1:0];
		pop        = 1'b0;
		fresh_go   = 1'b0;

		unique case (st_q)
			S_IDLE: begin
				if (head.valid) begin
					if (c.mode == MODE_FLUSH) begin
						pop = 1'b1;
						if (phase_q == PH_IDLE) begin
							// Send complete text, then slide the partial character down.
							n_st     = S_RUN;
							n_rd     = '0;
							n_end    = cs_q;
							n_kind   = KIND_TEXT;
							n_ovf    = 1'b0;
							n_each   = 1'b0;
							n_tail   = TAIL_MOVE;
							n_mv_src = cs_q;
							n_mv_n   = cnt_q - cs_q;
							n_mv_j   = '0;
							n_cnt    = cnt_q - cs_q;
							n_cs     = '0;
						end
					end else begin
						case (phase_q)
							PH_IDLE: begin
								if (need_q == 2'd0) begin
									fresh_go = 1'b1;
								end else if (c.is_cont) begin
									pop     = 1'b1;
									wr_en   = 1'b1;
									n_cnt   = cnt_inc;
									n_need  = need_q - 2'd1;
									if (need_q == 2'd1) begin
										n_cs = cnt_inc;
										if (cnt_inc >= lim) begin
											n_st    = S_RUN;
											n_rd    = '0;
											n_end   = cnt_inc;
											n_kind  = KIND_TEXT;
											n_ovf   = 1'b0;
											n_each  = 1'b0;
											n_tail  = TAIL_DONE;
											n_cnt   = '0;
											n_cs    = '0;
											n_need  = 2'd0;
										end
									end
								end else begin
									// Broken character: text, then each held byte as bad.
									pop        = 1'b1;
									n_cur      = c;
									n_st       = S_RUN;
									n_rd       = '0;
									n_end      = cs_q;
									n_kind     = KIND_TEXT;
									n_ovf      = 1'b0;
									n_each     = 1'b0;
									n_tail     = TAIL_FRESH;
									n_bad_pend = 1'b1;
									n_bad_lo   = cs_q;
									n_bad_hi   = cnt_q;
									n_cnt      = '0;
									n_cs       = '0;
									n_need     = 2'd0;
								end
							end
							PH_ESC: begin
								pop   = 1'b1;
								wr_en = 1'b1;
								n_cnt = cnt_inc;
								if (c.is_o) begin
									n_phase = PH_ESC_O;
								end else if (c.is_lbr) begin
									n_phase = PH_CSI_FIRST;
								end else begin
									n_st    = S_RUN;
									n_rd    = '0;
									n_end   = cnt_inc;
									n_kind  = KIND_ESC;
									n_ovf   = 1'b0;
									n_each  = 1'b0;
									n_tail  = TAIL_DONE;
									n_cnt   = '0;
									n_cs    = '0;
									n_need  = 2'd0;
									n_phase = PH_IDLE;
								end
							end
							PH_ESC_O: begin
								pop     = 1'b1;
								wr_en   = 1'b1;
								n_st    = S_RUN;
								n_rd    = '0;
								n_end   = cnt_inc;
								n_kind  = KIND_ESC;
								n_ovf   = 1'b0;
								n_each  = 1'b0;
								n_tail  = TAIL_DONE;
								n_cnt   = '0;
								n_cs    = '0;
								n_need  = 2'd0;
								n_phase = PH_IDLE;
							end
							PH_CSI_FIRST, PH_CSI_BODY: begin
								pop = 1'b1;
								if ((!csi_param && !c.is_final) || (cnt_q >= lim)) begin
									// Sequence ends without this byte, which is redone afresh.
									n_cur   = c;
									n_st    = S_RUN;
									n_rd    = '0;
									n_end   = cnt_q;
									n_kind  = KIND_ESC;
									n_ovf   = csi_param || c.is_final;
									n_each  = 1'b0;
									n_tail  = TAIL_FRESH;
									n_cnt   = '0;
									n_cs    = '0;
									n_need  = 2'd0;
									n_phase = PH_IDLE;
								end else begin
									wr_en = 1'b1;
									n_cnt = cnt_inc;
									if (c.is_final) begin
										n_st    = S_RUN;
										n_rd    = '0;
										n_end   = cnt_inc;
										n_kind  = KIND_ESC;
										n_ovf   = 1'b0;
										n_each  = 1'b0;
										n_tail  = TAIL_DONE;
										n_cnt   = '0;
										n_cs    = '0;
										n_need  = 2'd0;
										n_phase = PH_IDLE;
									end else begin
										n_phase = PH_CSI_BODY;
									end
								end
							end
							default: begin
								n_cnt   = '0;
								n_cs    = '0;
								n_need  = 2'd0;
								n_phase = PH_IDLE;
							end
						endcase
					end
				end
			end
			S_FRESH: begin
				fresh_go = 1'b1;
			end
			S_RUN: begin
				if (rd_q >= end_q) begin
					if (bad_pend_q) begin
						n_rd       = bad_lo_q;
						n_end      = bad_hi_q;
						n_kind     = KIND_BAD;
						n_ovf      = 1'b0;
						n_each     = 1'b1;
						n_bad_pend = 1'b0;
					end else begin
						unique case (tail_q)
							TAIL_FRESH: n_st = S_FRESH;
							TAIL_MOVE:  n_st = S_MOVE;
							default:    n_st = S_IDLE;
						endcase
					end
				end else if (slot_free) begin
					emit_req = 1'b1;
					e_byte   = rd_data;
					e_kind   = kind_q;
					e_ovf    = ovf_q;
					e_end    = each_q || ((rd_q + CNT_W'(1)) == end_q);
					n_rd     = rd_q + CNT_W'(1);
				end
			end
			S_MOVE: begin
				if (mv_j_q == mv_n_q) begin
					n_st = S_IDLE;
				end else begin
					rd_idx  = IDX_W'(mv_src_q + mv_j_q);
					wr_en   = 1'b1;
					wr_idx  = mv_j_q[IDX_W-1:0];
					wr_data = rd_data;
					n_mv_j  = mv_j_q + CNT_W'(1);
				end
			end
			default: n_st = S_IDLE;
		endcase

		// A byte taken with no partial character held. Held text that must go
		// first is sent as a run, after which the byte comes back here.
		if (fresh_go) begin
			if (c.is_ctrl || (c.lead_len == 3'd0) || (cs_plus_lead > {1'b0, lim})) begin
				if (cs_q != '0) begin
					pop     = (st_q == S_IDLE);
					n_cur   = c;
					n_st    = S_RUN;
					n_rd    = '0;
					n_end   = cs_q;
					n_kind  = KIND_TEXT;
					n_ovf   = 1'b0;
					n_each  = 1'b0;
					n_tail  = TAIL_FRESH;
					n_cnt   = '0;
					n_cs    = '0;
					n_need  = 2'd0;
					n_phase = PH_IDLE;
				end else if (c.is_esc) begin
					pop     = (st_q == S_IDLE);
					wr_en   = 1'b1;
					wr_idx  = '0;
					n_cnt   = CNT_W'(1);
					n_phase = PH_ESC;
					n_st    = S_IDLE;
				end else if (slot_free) begin
					pop      = (st_q == S_IDLE);
					emit_req = 1'b1;
					e_byte   = c.data;
					e_kind   = c.is_ctrl ? KIND_CTRL : KIND_BAD;
					e_end    = 1'b1;
					e_ovf    = 1'b0;
					n_st     = S_IDLE;
				end
			end else begin
				pop    = (st_q == S_IDLE);
				wr_en  = 1'b1;
				wr_idx = cs_q[IDX_W-1:0];
				n_cnt  = cs_inc;
				n_need = 2'(c.lead_len - 3'd1);
				n_st   = S_IDLE;
				if (c.lead_len == 3'd1) begin
					n_cs = cs_inc;
					if (cs_inc >= lim) begin
						n_st   = S_RUN;
						n_rd   = '0;
						n_end  = cs_inc;
						n_kind = KIND_TEXT;
						n_ovf  = 1'b0;
						n_each = 1'b0;
						n_tail = TAIL_DONE;
						n_cnt  = '0;
						n_cs   = '0;
						n_need = 2'd0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cs_q       <= '0;
			need_q     <= 2'd0;
			phase_q    <= PH_IDLE;
			st_q       <= S_IDLE;
			bad_pend_q <= 1'b0;
			limit_q    <= CFG_W'(LIMIT_RESET);
			ov_q       <= 1'b0;
		end else begin
			cnt_q      <= n_cnt;
			cs_q       <= n_cs;
			need_q     <= n_need;
			phase_q    <= n_phase;
			st_q       <= n_st;
			bad_pend_q <= n_bad_pend;
			if (cfg_we) limit_q <= cfg_data;
			if (slot_free) ov_q <= emit_req;
		end
	end

	always_ff @(posedge clk) begin
		rd_q     <= n_rd;
		end_q    <= n_end;
		kind_q   <= n_kind;
		ovf_q    <= n_ovf;
		each_q   <= n_each;
		tail_q   <= n_tail;
		bad_lo_q <= n_bad_lo;
		bad_hi_q <= n_bad_hi;
		cur_q    <= n_cur;
		mv_src_q <= n_mv_src;
		mv_n_q   <= n_mv_n;
		mv_j_q   <= n_mv_j;
		if (wr_en) pend_q[wr_idx] <= wr_data;
		if (slot_free && emit_req) begin
			obyte_q <= e_byte;
			okind_q <= e_kind;
			oend_q  <= e_end;
			oovf_q  <= e_ovf;
		end
	end

	assign tokens.valid      = ov_q;
	assign tokens.token_byte = obyte_q;
	assign tokens.token_kind = okind_q;
	assign tokens.token_end  = oend_q;
	assign tokens.overflow   = oovf_q;

endmodule

>>> design/terminal_byte_tokenizer.sv
// Top level of the terminal byte tokenizer: front end, command queue and back end.
// A word is written into the command queue and reaches the back end from its head; a token
//   byte is held in the back end's output register once the back end sends it.
// The back end decides on one input word at a time; a run sends each token byte and then
//   closes, a byte handled again after a run is decided anew, and a flush in text moves
//   each partial byte down; a stalled token sink holds the back end.
// Reset: asynchronous, active low; buffer empty, parse idle, limit back to 16.
`timescale 1ns / 1ps

module terminal_byte_tokenizer (
	input  logic                      clk,
	input  logic                      arst_n,
	tbt_byte_if.sink                  bytes,
	tbt_token_if.source               tokens,
	input  logic                      cfg_we,
	input  logic [tbt_pkg::CFG_W-1:0] cfg_data
);
	import tbt_pkg::*;

	// The front end classifies every accepted word (control, escape, UTF-8 lead
	// length, continuation, CSI parameter and final bytes) and places it in a short
	// queue, so input keeps flowing while the back end sends a token, until the queue fills.
	q_head_t head;
	logic    pop;

	tbt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.head   (head),
		.pop    (pop)
	);

	// The back end owns the token buffer and the parse state. It takes one word
	// from the queue per decision, and sends buffered tokens one byte per cycle, unless
	// the token sink stalls, through its output register, which decouples it from the sink.
	tbt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.tokens   (tokens)
	);

`ifndef SYNTHESIS
	// Only a cut escape sequence carries the overflow mark.
	a_ovf_escape: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.overflow |-> tokens.token_kind == KIND_ESC)
		else $error("overflow set on a token that is not an escape");

	// Control and bad bytes are always tokens of a single byte.
	a_single_byte: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && (tokens.token_kind == KIND_CTRL || tokens.token_kind == KIND_BAD)
		|-> tokens.token_end)
		else $error("control or bad token longer than one byte");

	// Text never carries a control byte.
	a_text_printable: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.token_kind == KIND_TEXT
		|-> tokens.token_byte >= 8'h20 && tokens.token_byte != 8'h7F)
		else $error("control byte inside a text token");
`endif

endmodule
